[rtl/core/i2c_mbr_pkg.sv]
// Package: item types, phase codes and register indexes for the I2C byte read unit.
package i2c_mbr_pkg;

  typedef struct packed {
    logic start_request;
    logic sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] read_byte;
  } out_item_t;

  typedef enum logic [12:0] {
    PH_IDLE = 13'b0000000000001,
    PH_ST0  = 13'b0000000000010,
    PH_ST1  = 13'b0000000000100,
    PH_ST2  = 13'b0000000001000,
    PH_WHI  = 13'b0000000010000,
    PH_WLO  = 13'b0000000100000,
    PH_ACK  = 13'b0000001000000,
    PH_RHI  = 13'b0000010000000,
    PH_RLO  = 13'b0000100000000,
    PH_NHI  = 13'b0001000000000,
    PH_NLO  = 13'b0010000000000,
    PH_SP0  = 13'b0100000000000,
    PH_SP1  = 13'b1000000000000
  } phase_e;

  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] CFG_SLAVE_ADDRESS  = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CFG_HALF_BIT_TICKS = 1'b1;

  localparam logic [6:0]  SLAVE_ADDRESS_RST  = 7'd80;
  localparam logic [15:0] HALF_BIT_TICKS_RST = 16'd1000;

endpackage

[rtl/core/i2c_master_byte_read_unit.sv]
// Top level: I2C master that runs one single-byte read transaction, one tick per item.
//
// Each input item is one tick of the bus timer and yields exactly one result item that
// carries the SCL/SDA drive for that tick, busy, a one-tick done pulse, the address
// acknowledge flag and the last byte read. Items are taken one per cycle unless stalled: the
// phase sequencer and its delay counter update in the cycle an item is accepted, and the result
// lands in an output register that the next item may replace in the same cycle it is taken.
// Every line setting lasts half_bit_ticks items (zero counts as one, the value is capped at
// 2**WAIT_WIDTH). slave_address is captured at the start of the address phase;
// half_bit_ticks acts at once. Lines are open drain: 1 means released.
module i2c_master_byte_read_unit #(
  parameter int unsigned WAIT_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  i2c_mbr_pkg::in_item_t               in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output i2c_mbr_pkg::out_item_t              out_item_o,
  input  logic                                cfg_we_i,
  input  logic [i2c_mbr_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [i2c_mbr_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import i2c_mbr_pkg::*;

  localparam int unsigned CntWidth = ((WAIT_WIDTH > 16) ? WAIT_WIDTH : 16) + 1;
  localparam logic [CntWidth-1:0] DelayCap = {{(CntWidth-1){1'b0}}, 1'b1} << WAIT_WIDTH;

  logic [6:0]            slave_address_q;
  logic [15:0]           half_bit_ticks_q;
  phase_e                phase_q, phase_d;
  logic [2:0]            bit_index_q, bit_index_d;
  logic [WAIT_WIDTH-1:0] wait_count_q, wait_count_d;
  logic [7:0]            shift_byte_q, shift_byte_d;
  logic                  ack_flag_q, ack_flag_d;
  logic [7:0]            held_byte_q, held_byte_d;
  logic                  out_valid_q;
  out_item_t             out_item_q, out_item_d;

  logic                  in_accept;
  logic [CntWidth-1:0]   delay_ticks;
  logic [CntWidth-1:0]   count_inc;
  logic                  last_tick;
  logic                  busy;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q  <= SLAVE_ADDRESS_RST;
      half_bit_ticks_q <= HALF_BIT_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLAVE_ADDRESS:  slave_address_q  <= cfg_data_i[6:0];
        CFG_HALF_BIT_TICKS: half_bit_ticks_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // delay length and end-of-phase detect
  always_comb begin
    delay_ticks = CntWidth'(half_bit_ticks_q);
    if (half_bit_ticks_q == 16'd0) begin
      delay_ticks = {{(CntWidth-1){1'b0}}, 1'b1};
    end else if (delay_ticks > DelayCap) begin
      delay_ticks = DelayCap;
    end
    count_inc = CntWidth'(wait_count_q) + {{(CntWidth-1){1'b0}}, 1'b1};
    last_tick = (count_inc >= delay_ticks);
  end

  always_comb begin
    phase_d      = phase_q;
    bit_index_d  = bit_index_q;
    wait_count_d = wait_count_q;
    shift_byte_d = shift_byte_q;
    ack_flag_d   = ack_flag_q;
    held_byte_d  = held_byte_q;
    out_item_d   = '0;
    out_item_d.scl_out = 1'b1;
    out_item_d.sda_out = 1'b1;
    busy = 1'b1;

    case (phase_q)
      PH_ST0: ;
      PH_ST1: out_item_d.sda_out = 1'b0;
      PH_ST2: begin
        out_item_d.sda_out = 1'b0;
        out_item_d.scl_out = 1'b0;
      end
      PH_WHI: out_item_d.sda_out = shift_byte_q[7];
      PH_WLO: begin
        out_item_d.sda_out = shift_byte_q[7];
        out_item_d.scl_out = 1'b0;
      end
      PH_ACK: ;
      PH_RHI: ;
      PH_RLO: out_item_d.scl_out = 1'b0;
      PH_NHI: ;
      PH_NLO: out_item_d.scl_out = 1'b0;
      PH_SP0: out_item_d.sda_out = 1'b0;
      PH_SP1: ;
      default: busy = 1'b0;
    endcase

    if (!busy) begin
      wait_count_d = '0;
      if (in_item_i.start_request) begin
        phase_d     = PH_ST0;
        ack_flag_d  = 1'b0;
        bit_index_d = 3'd0;
      end else begin
        phase_d = PH_IDLE;
      end
    end else if (!last_tick) begin
      wait_count_d = count_inc[WAIT_WIDTH-1:0];
    end else begin
      wait_count_d = '0;
      case (phase_q)
        PH_ST0: phase_d = PH_ST1;
        PH_ST1: phase_d = PH_ST2;
        PH_ST2: begin
          shift_byte_d = {slave_address_q, 1'b1};
          bit_index_d  = 3'd0;
          phase_d      = PH_WHI;
        end
        PH_WHI: phase_d = PH_WLO;
        PH_WLO: begin
          shift_byte_d = {shift_byte_q[6:0], 1'b0};
          if (bit_index_q == 3'd7) begin
            bit_index_d = 3'd0;
            phase_d     = PH_ACK;
          end else begin
            bit_index_d = bit_index_q + 3'd1;
            phase_d     = PH_WHI;
          end
        end
        PH_ACK: begin
          if (!in_item_i.sda_in) begin
            ack_flag_d   = 1'b1;
            shift_byte_d = 8'd0;
            bit_index_d  = 3'd0;
            phase_d      = PH_RHI;
          end else begin
            ack_flag_d = 1'b0;
            phase_d    = PH_SP0;
          end
        end
        PH_RHI: begin
          shift_byte_d = {shift_byte_q[6:0], in_item_i.sda_in};
          phase_d      = PH_RLO;
        end
        PH_RLO: begin
          if (bit_index_q == 3'd7) begin
            held_byte_d = shift_byte_q;
            bit_index_d = 3'd0;
            phase_d     = PH_NHI;
          end else begin
            bit_index_d = bit_index_q + 3'd1;
            phase_d     = PH_RHI;
          end
        end
        PH_NHI: phase_d = PH_NLO;
        PH_NLO: phase_d = PH_SP0;
        PH_SP0: phase_d = PH_SP1;
        default: begin
          out_item_d.done_res = 1'b1;
          phase_d             = PH_IDLE;
        end
      endcase
    end

    out_item_d.busy_res     = busy;
    out_item_d.ack_received = ack_flag_d;
    out_item_d.read_byte    = held_byte_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_index_q  <= 3'd0;
      wait_count_q <= '0;
      shift_byte_q <= 8'd0;
      ack_flag_q   <= 1'b0;
      held_byte_q  <= 8'd0;
    end else if (in_accept) begin
      phase_q      <= phase_d;
      bit_index_q  <= bit_index_d;
      wait_count_q <= wait_count_d;
      shift_byte_q <= shift_byte_d;
      ack_flag_q   <= ack_flag_d;
      held_byte_q  <= held_byte_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_item_q <= out_item_d;
    end
  end

endmodule
